// ===== design/cmnhd_pkg.sv =====
// package for the contact matrix new-hit detector
// holds matrix geometry, payload structs, register indexes and the grid mask
// no dependencies
`default_nettype none

package cmnhd_pkg;

  // matrix geometry (at most 8 x 8)
  localparam int unsigned ROWS = 8;
  localparam int unsigned COLS = 8;

  localparam int unsigned CELLS  = 64;
  localparam int unsigned RC_W   = 3;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned ELAP_W = 10;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CALIBRATION_MODE = 2'd0,
    CFG_UNMAPPED_MASK    = 2'd1,
    CFG_QUIET_THRESHOLD  = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_index_e;

  localparam logic [CELLS-1:0]  UNMAPPED_RESET = 64'h0000_0000_0000_4080;
  localparam logic [TIME_W-1:0] QUIET_RESET    = 16'd500;

  typedef struct packed {
    logic [CELLS-1:0]  contacts;
    logic [ELAP_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic            hit_valid;
    logic [RC_W-1:0] hit_row;
    logic [RC_W-1:0] hit_col;
    logic            quiet;
    logic            latches_cleared;
  } out_item_t;

  // result of the first-candidate search
  typedef struct packed {
    logic            found;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } pick_t;

  // cells inside the configured grid
  function automatic logic [CELLS-1:0] grid_mask();
    logic [CELLS-1:0] m;
    m = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (r < int'(ROWS) && c < int'(COLS)) begin
          m[r*8+c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  localparam logic [CELLS-1:0] GRID_MASK = grid_mask();

endpackage

`default_nettype wire

// ===== design/cmnhd_find.sv =====
// first candidate cell in row-major order
// depends on cmnhd_pkg
`default_nettype none

module cmnhd_find (
  input  wire logic [cmnhd_pkg::CELLS-1:0] cand_i,
  output cmnhd_pkg::pick_t                 pick_o
);
  import cmnhd_pkg::*;

  logic [7:0] row_any;
  logic [7:0] row_bits;
  logic [RC_W-1:0] row_sel;
  logic [RC_W-1:0] col_sel;

  // per-row or-reduce
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      row_any[r] = |cand_i[r*8 +: 8];
    end
  end

  // lowest row with a candidate
  always_comb begin
    row_sel = '0;
    for (int r = 7; r >= 0; r--) begin
      if (row_any[r]) begin
        row_sel = RC_W'(r);
      end
    end
  end

  assign row_bits = cand_i[{row_sel, 3'b000} +: 8];

  // lowest column within that row
  always_comb begin
    col_sel = '0;
    for (int c = 7; c >= 0; c--) begin
      if (row_bits[c]) begin
        col_sel = RC_W'(c);
      end
    end
  end

  assign pick_o.found = |row_any;
  assign pick_o.row   = row_sel;
  assign pick_o.col   = col_sel;

endmodule

`default_nettype wire

// ===== design/contact_matrix_new_hit_detector.sv =====
// top level of the contact matrix new-hit detector
// depends on cmnhd_pkg and cmnhd_find
`default_nettype none

// One input transfer is one scan snapshot of the 8x8 contact matrix plus the
// milliseconds since the previous snapshot; each one produces exactly one
// result transfer. The snapshot lands in an input register, the hit search,
// latch update and quiet timer are worked out combinationally from that
// register and the latch state, and the result is held in an output register.
// A new snapshot is taken every cycle while the result side keeps up, so the
// rate is one snapshot per clock; a result is offered from the output register
// once its snapshot has passed through the input register. The clock rate is
// limited by the 64-cell first-hit search feeding the latch update, which
// must finish before the next snapshot sees the latches. Configuration writes
// are always ready and take effect on the next snapshot worked on; write only
// while no snapshot is in flight. An unmapped hit in normal mode is latched
// silently; in calibration mode any new contact is reported and nothing is
// latched. After the programmed quiet threshold of quiet time (timer starts
// counting on the second quiet scan) all latches drop and latches_cleared is
// flagged.

module contact_matrix_new_hit_detector (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // snapshot channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire cmnhd_pkg::in_item_t       in_item_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output cmnhd_pkg::out_item_t           out_item_o,
  // configuration write channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire cmnhd_pkg::cfg_index_e     cfg_index_i,
  input  wire logic [63:0]               cfg_data_i
);
  import cmnhd_pkg::*;

  // configuration registers
  logic              calib_q;
  logic [CELLS-1:0]  unmapped_q;
  logic [TIME_W-1:0] quiet_clear_q;

  // input register
  logic     in_valid_q;
  in_item_t in_q;

  // latch and quiet timer state
  logic [CELLS-1:0]  seated_q, seated_d;
  logic              armed_q, armed_d;
  logic [TIME_W-1:0] qtime_q, qtime_d;

  // output register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic advance;     // result register can take the worked-on snapshot
  logic commit;      // snapshot in the input register moves to the output
  logic in_xfer;

  logic [CELLS-1:0]  contacts;
  logic [CELLS-1:0]  cand;
  pick_t             pick;
  logic [5:0]        pick_idx;
  logic [CELLS-1:0]  pick_bit;
  logic              report;
  logic              quiet;
  logic              cleared;
  logic [TIME_W:0]   qsum;
  logic [TIME_W-1:0] qsat;

  // config port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q       <= 1'b0;
      unmapped_q    <= UNMAPPED_RESET;
      quiet_clear_q <= QUIET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CALIBRATION_MODE: calib_q       <= cfg_data_i[0];
        CFG_UNMAPPED_MASK:    unmapped_q    <= cfg_data_i;
        CFG_QUIET_THRESHOLD:  quiet_clear_q <= cfg_data_i[TIME_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // pipeline handshake: output frees up, input register drains into it
  assign advance    = !out_valid_q || !out_stall_i;
  assign commit     = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_item_i;
    end
  end

  // candidates: in contact, inside the grid and not yet latched
  assign contacts = in_q.contacts & GRID_MASK;
  assign cand     = contacts & ~seated_q;

  cmnhd_find u_find (
    .cand_i (cand),
    .pick_o (pick)
  );

  assign pick_idx = {pick.row, pick.col};
  assign pick_bit = CELLS'(1) << pick_idx;

  // calibration reports anything, normal mode only mapped cells
  assign report = pick.found && (calib_q || !unmapped_q[pick_idx]);
  assign quiet  = !pick.found && ((contacts & ~unmapped_q) == '0);

  // saturating quiet-time accumulate
  assign qsum = {1'b0, qtime_q} + (TIME_W+1)'(in_q.elapsed_ms);
  assign qsat = qsum[TIME_W] ? TIME_MAX : qsum[TIME_W-1:0];

  always_comb begin
    seated_d = seated_q;
    armed_d  = 1'b0;
    qtime_d  = '0;
    cleared  = 1'b0;
    if (pick.found && !calib_q) begin
      seated_d = seated_q | pick_bit;
    end
    if (quiet) begin
      if (!armed_q) begin
        // first quiet scan only arms the timer
        armed_d = 1'b1;
      end else if (qsat >= quiet_clear_q) begin
        seated_d = '0;
        cleared  = 1'b1;
      end else begin
        armed_d = 1'b1;
        qtime_d = qsat;
      end
    end
  end

  always_comb begin
    out_d.hit_valid       = report;
    out_d.hit_row         = report ? pick.row : '0;
    out_d.hit_col         = report ? pick.col : '0;
    out_d.quiet           = quiet;
    out_d.latches_cleared = cleared;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seated_q <= '0;
      armed_q  <= 1'b0;
      qtime_q  <= '0;
    end else if (commit) begin
      seated_q <= seated_d;
      armed_q  <= armed_d;
      qtime_q  <= qtime_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a timeout clear leaves no latch standing
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && cleared |=> seated_q == '0)
    else $error("latches remain after quiet timeout clear");

  // a disarmed timer holds no time
  a_disarmed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> qtime_q == '0)
    else $error("quiet time nonzero while timer disarmed");

  // a reported hit and a quiet flag never come together
  a_hit_not_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.hit_valid |-> !out_q.quiet)
    else $error("hit reported on a quiet scan");

  // clearing only happens on quiet scans
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.latches_cleared |-> out_q.quiet)
    else $error("latches cleared on a scan that was not quiet");

endmodule

`default_nettype wire

// ===== tb/hit_detector_checker.sv =====
// checker for the contact matrix new-hit detector: predicts one report per scan
// transfer and compares it with every result transfer
// depends on cmnhd_pkg
`default_nettype none

module hit_detector_checker (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire cmnhd_pkg::in_item_t   in_item_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire cmnhd_pkg::out_item_t  out_item_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire cmnhd_pkg::cfg_index_e cfg_index_i,
  input  wire logic [63:0]           cfg_data_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cmnhd_pkg::*;

  logic              calib_mode;
  logic [CELLS-1:0]  unmapped;
  logic [TIME_W-1:0] clear_ms;
  logic [CELLS-1:0]  seated;
  logic              timer_armed;
  logic [TIME_W-1:0] quiet_ms;
  out_item_t         expected_reports[$];
  int                errors;

  // works out the report for one scan and advances the latch and timer state
  function automatic out_item_t predict_scan(in_item_t scan);
    logic [CELLS-1:0] live;
    logic [CELLS-1:0] fresh;
    logic [TIME_W:0]  sum;
    logic             found;
    out_item_t        res;
    live  = scan.contacts & GRID_MASK;
    fresh = live & ~seated;
    found = 1'b0;
    res   = '0;
    for (int r = 0; r < int'(ROWS); r++) begin
      for (int c = 0; c < int'(COLS); c++) begin
        if (!found && fresh[r*8+c]) begin
          found = 1'b1;
          if (calib_mode || !unmapped[r*8+c]) begin
            res.hit_valid = 1'b1;
            res.hit_row   = RC_W'(r);
            res.hit_col   = RC_W'(c);
          end
          if (!calib_mode) begin
            seated[r*8+c] = 1'b1;
          end
        end
      end
    end
    res.quiet = !found && ((live & ~unmapped) == '0);
    if (!res.quiet) begin
      timer_armed = 1'b0;
      quiet_ms    = '0;
    end else if (!timer_armed) begin
      timer_armed = 1'b1;
      quiet_ms    = '0;
    end else begin
      sum      = {1'b0, quiet_ms} + (TIME_W+1)'(scan.elapsed_ms);
      quiet_ms = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      if (quiet_ms >= clear_ms) begin
        seated              = '0;
        timer_armed         = 1'b0;
        quiet_ms            = '0;
        res.latches_cleared = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      calib_mode  = 1'b0;
      unmapped    = UNMAPPED_RESET;
      clear_ms    = QUIET_RESET;
      seated      = '0;
      timer_armed = 1'b0;
      quiet_ms    = '0;
      errors      = 0;
      expected_reports.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result transfer with nothing expected: %p", $time, out_item_i);
          end
        end else begin
          want = expected_reports.pop_front();
          if (out_item_i !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: report mismatch: expected hit=%0b row=%0d col=%0d quiet=%0b clr=%0b",
                       $time, want.hit_valid, want.hit_row, want.hit_col, want.quiet,
                       want.latches_cleared);
              $display("%0t:                     actual hit=%0b row=%0d col=%0d quiet=%0b clr=%0b",
                       $time, out_item_i.hit_valid, out_item_i.hit_row, out_item_i.hit_col,
                       out_item_i.quiet, out_item_i.latches_cleared);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CALIBRATION_MODE: calib_mode = cfg_data_i[0];
          CFG_UNMAPPED_MASK:    unmapped   = cfg_data_i;
          CFG_QUIET_THRESHOLD:  clear_ms   = cfg_data_i[TIME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_reports.push_back(predict_scan(in_item_i));
      end
    end
    mismatch_count_o <= errors;
    pending_o        <= expected_reports.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench top for the contact matrix new-hit detector: drives scan snapshots
// and register writes, toggles stalls and gives the verdict
// depends on cmnhd_pkg, hit_detector_checker and the detector itself
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmnhd_pkg::*;

  // no transfer of any kind for this long means the block is hung
  localparam int WATCHDOG_CYCLES = 2000;
  // settle time after the last report
  localparam int DRAIN_CYCLES    = 8;
  // length of the long receiver hold-off that fills the pipeline
  localparam int HOLD_CYCLES     = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_e  cfg_index;
  logic [63:0] cfg_data;
  int          mismatches;
  int          pending;

  // idling controls, percent per cycle
  int          idle_pct  = 0;
  int          stall_pct = 0;
  bit          hold_req  = 1'b0;
  int          hold_left = 0;
  int          stuck_cycles = 0;

  // our copy of the unmapped mask, used to aim contacts at unmapped cells
  logic [CELLS-1:0] unmapped_copy = UNMAPPED_RESET;

  contact_matrix_new_hit_detector u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  hit_detector_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // hang detection: counts cycles in which no transfer happens on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_CYCLES) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // one scan transfer, with a random gap ahead of it; returns at a falling edge
  task automatic send_scan(input logic [CELLS-1:0] contacts,
                           input logic [ELAP_W-1:0] elapsed);
    int gap;
    bit taken;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.contacts   = contacts;
    in_item.elapsed_ms = elapsed;
    in_valid           = 1'b1;
    taken              = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
  endtask

  // stop offering scans and wait until every report has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // register write, only called with nothing in flight
  task automatic write_reg(input cfg_index_e idx, input logic [63:0] value);
    bit taken;
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    taken     = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
      @(negedge clk);
    end
    cfg_valid = 1'b0;
    if (idx == CFG_UNMAPPED_MASK) begin
      unmapped_copy = value;
    end
  endtask

  // mostly sparse presses and quiet scans, now and then dense or unmapped-only
  function automatic logic [CELLS-1:0] random_contacts();
    logic [CELLS-1:0] v;
    int kind;
    kind = $urandom_range(0, 9);
    v    = '0;
    case (kind)
      0, 1, 2: v = '0;
      3, 4, 5: v[$urandom_range(0, CELLS-1)] = 1'b1;
      6, 7:    repeat ($urandom_range(2, 4)) v[$urandom_range(0, CELLS-1)] = 1'b1;
      8:       v = {$urandom, $urandom};
      default: v = {$urandom, $urandom} & unmapped_copy;
    endcase
    return v;
  endfunction

  function automatic logic [ELAP_W-1:0] random_elapsed();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       return '0;
      1:       return '1;
      default: return ELAP_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [63:0] random_mask();
    int kind;
    kind = $urandom_range(0, 4);
    case (kind)
      0:       return '0;
      1:       return '1;
      2:       return UNMAPPED_RESET;
      default: return {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] random_threshold();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return 64'(QUIET_RESET);
      3:       return 64'(TIME_MAX);
      default: return 64'($urandom_range(2, 3000));
    endcase
  endfunction

  initial begin
    int sent;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CALIBRATION_MODE;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, reset settings: normal mode, cells (0,7) and (1,6) unmapped
    send_scan('0, '0);                              // first quiet scan arms the timer
    send_scan('0, '1);                              // threshold reached, latches drop
    send_scan('1, '1);                              // full matrix, hit at (0,0)
    send_scan('1, '0);                              // (0,0) latched, next is (0,1)
    send_scan(64'h80, 10'd5);                       // unmapped (0,7) latched silently
    send_scan(64'h80, 10'd5);                       // only unmapped contact left: quiet
    send_scan(64'h8000_0000_0000_0000, '0);         // last cell (7,7)
    send_scan(64'h8000_0000_0000_4000, '0);         // unmapped (1,6) latched silently
    send_scan('0, 10'd499);                         // arms
    send_scan('0, 10'd499);                         // just short of the threshold
    send_scan('0, 10'd1);                           // exactly at threshold, clears
    send_scan(64'h8000_0000_0000_0000, '0);         // (7,7) reported again after clear

    // calibration mode, every cell unmapped, zero threshold
    wait_drained();
    write_reg(CFG_CALIBRATION_MODE, 64'd1);
    write_reg(CFG_UNMAPPED_MASK, '1);
    write_reg(CFG_QUIET_THRESHOLD, 64'd0);
    send_scan(64'h80, 10'd3);                       // unmapped cell still reported
    send_scan(64'h80, 10'd3);                       // not latched, so reported again
    send_scan('0, '0);                              // arms
    send_scan('0, '0);                              // zero threshold clears at once
    send_scan('1, '1);                              // calibration report of (0,0)

    // index beyond the register list, then normal mode at the other extremes
    wait_drained();
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_CALIBRATION_MODE, 64'd0);
    write_reg(CFG_UNMAPPED_MASK, '0);
    write_reg(CFG_QUIET_THRESHOLD, 64'(TIME_MAX));
    send_scan('1, '1);                              // hit at (0,0)
    // long quiet run: the timer saturates at its top value and then clears
    repeat (70) send_scan('0, '1);

    // random phases, each with its own settings and idling mix
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_reg(CFG_CALIBRATION_MODE, 64'($urandom_range(0, 3) == 0));
      write_reg(CFG_UNMAPPED_MASK, random_mask());
      write_reg(CFG_QUIET_THRESHOLD, random_threshold());
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      // back-pressure: the result side holds off while scans keep coming
      if (ph == 0) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 19) == 0) begin
          // a stretch of quiet scans so the timer gets to run out
          repeat ($urandom_range(3, 10)) begin
            send_scan('0, random_elapsed());
            sent++;
          end
        end else begin
          send_scan(random_contacts(), random_elapsed());
          sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
